// ===== rtl/ptcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptcc_pkg: shared types and constants for the paged tag cache commit unit
// Field widths, saturation limit and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ptcc_pkg;

	localparam int TAG_W   = 32;
	localparam int ENTRY_W = 64;
	localparam int IDX_W   = 4;
	localparam int VIOL_W  = 16;

	localparam logic [VIOL_W-1:0] VIOL_MAX = {VIOL_W{1'b1}};

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture the input word
		logic match;   // tag compare and fill read
		logic commit;  // update state and load the result word
	} ptcc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_free;  // result register can take a new word this cycle
	} ptcc_sts_t;

endpackage

// ===== rtl/ptcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptcc_ctrl: commit sequencer
// Steps each accepted word through match and commit, and drives in_stall.
// ----------------------------------------------------------------------------
module ptcc_ctrl import ptcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  ptcc_sts_t sts,
	output ptcc_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   accept;
	logic   commit_go;

	// a new word enters when idle or while the current one commits
	assign commit_go = (state_q == ST_COMMIT) && sts.out_free;
	assign in_stall  = !((state_q == ST_IDLE) || commit_go);
	assign accept    = in_valid && !in_stall;

	assign cmd.load   = accept;
	assign cmd.match  = (state_q == ST_MATCH);
	assign cmd.commit = commit_go;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_MATCH;
				end
				ST_MATCH: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_go) state_q <= accept ? ST_MATCH : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/ptcc_dp.sv =====
// ----------------------------------------------------------------------------
// ptcc_dp: commit datapath
// Page tags, fill memory, entry memory, allocation pointer, violation counter
// and the result register.
// ----------------------------------------------------------------------------
module ptcc_dp import ptcc_pkg::*; #(
	parameter int PAGES = 16,
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptcc_cmd_t          cmd,
	output ptcc_sts_t          sts,
	input  logic [TAG_W-1:0]   commit_tag,
	input  logic [ENTRY_W-1:0] entry_hash,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               rejected,
	output logic [IDX_W-1:0]   page_index,
	output logic [VIOL_W-1:0]  violation_count,
	output logic               store_ok
);

	localparam int PW = $clog2(PAGES);
	localparam int FW = $clog2(SLOTS + 1);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW = (PAGES * SLOTS > 1) ? $clog2(PAGES * SLOTS) : 1;
	localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES - 1);

	// input word
	logic [TAG_W-1:0]   tag_q;
	logic [ENTRY_W-1:0] entry_q;

	// page state
	logic [TAG_W-1:0]   tags_q [PAGES];
	logic [FW-1:0]      fill_mem [PAGES];
	logic [ENTRY_W-1:0] entry_mem [PAGES * SLOTS];
	logic [PW-1:0]      alloc_q;
	logic [VIOL_W-1:0]  viol_q;
	logic               ovf_q;

	// match stage results
	logic [PW-1:0] page_q;
	logic          hit_q;
	logic [FW-1:0] fill_rd_q;

	// result register
	logic              out_valid_q;
	logic              rejected_q;
	logic [IDX_W-1:0]  page_index_q;
	logic [VIOL_W-1:0] viol_out_q;
	logic              store_ok_q;

	logic               hit;
	logic [PW-1:0]      hit_page;
	logic               tag_zero;
	logic [FW-1:0]      fill_cur;
	logic [SW-1:0]      slot;
	logic [FW-1:0]      fill_new;
	logic               fill_ovf;
	logic [AW-1:0]      wr_addr;
	logic [VIOL_W-1:0]  viol_next;
	logic [PW+IDX_W-1:0] page_ext;

	// tag compare over all pages, highest match wins
	always_comb begin
		hit      = 1'b0;
		hit_page = '0;
		for (int p = 0; p < PAGES; p++) begin
			if (tags_q[p] == tag_q) begin
				hit      = 1'b1;
				hit_page = PW'(p);
			end
		end
	end

	// slot selection and write address
	assign tag_zero  = (tag_q == '0);
	assign fill_cur  = hit_q ? fill_rd_q : '0;
	assign slot      = (fill_cur >= FW'(SLOTS)) ? '0 : fill_cur[SW-1:0];
	assign fill_new  = FW'(slot) + FW'(1);
	assign fill_ovf  = (fill_new > FW'(SLOTS));
	assign wr_addr   = AW'(page_q) * AW'(SLOTS) + AW'(slot);
	assign viol_next = (tag_zero && (viol_q != VIOL_MAX)) ? viol_q + VIOL_W'(1) : viol_q;
	assign page_ext  = {{IDX_W{1'b0}}, page_q};

	assign sts.out_free = !out_valid_q || !out_stall;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q   <= commit_tag;
			entry_q <= entry_hash;
		end
	end

	// match stage: pick page and read its fill count
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_q     <= hit;
			page_q    <= hit ? hit_page : alloc_q;
			fill_rd_q <= fill_mem[hit_page];
		end
	end

	// fill and entry memories
	always_ff @(posedge clk) begin
		if (cmd.commit && !tag_zero) begin
			fill_mem[page_q]   <= fill_new;
			entry_mem[wr_addr] <= entry_q;
		end
	end

	// tags, allocation pointer, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PAGES; p++) tags_q[p] <= '0;
			alloc_q <= '0;
			viol_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.commit) begin
			viol_q <= viol_next;
			if (!tag_zero) begin
				ovf_q <= ovf_q | fill_ovf;
				if (!hit_q) begin
					tags_q[page_q] <= tag_q;
					alloc_q        <= (page_q == LAST_PAGE) ? '0 : page_q + PW'(1);
				end
			end
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rejected_q   <= tag_zero;
			page_index_q <= tag_zero ? '0 : page_ext[IDX_W-1:0];
			viol_out_q   <= viol_next;
			store_ok_q   <= (viol_next == '0) && !(ovf_q || (!tag_zero && fill_ovf));
		end
	end

	assign out_valid       = out_valid_q;
	assign rejected        = rejected_q;
	assign page_index      = page_index_q;
	assign violation_count = viol_out_q;
	assign store_ok        = store_ok_q;

endmodule

// ===== rtl/paged_tag_cache_commit_unit.sv =====
// ----------------------------------------------------------------------------
// paged_tag_cache_commit_unit: input capture, tag compare, then fill read-modify-write
// and result register at commit, held by out_stall; next word taken as the last commits
// reset clears tags, allocation pointer, counter and overflow flag; no clear pass
// ----------------------------------------------------------------------------
module paged_tag_cache_commit_unit import ptcc_pkg::*; #(
	parameter int PAGES = 16,
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TAG_W-1:0]   commit_tag,
	input  logic [ENTRY_W-1:0] entry_hash,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               rejected,
	output logic [IDX_W-1:0]   page_index,
	output logic [VIOL_W-1:0]  violation_count,
	output logic               store_ok
);

	ptcc_cmd_t cmd;
	ptcc_sts_t sts;

	// sequencer
	ptcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	ptcc_dp #(
		.PAGES (PAGES),
		.SLOTS (SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.commit_tag      (commit_tag),
		.entry_hash      (entry_hash),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.rejected        (rejected),
		.page_index      (page_index),
		.violation_count (violation_count),
		.store_ok        (store_ok)
	);

	// no two words accepted on back-to-back edges
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !(in_valid && !in_stall))
		else $error("input accepted on consecutive cycles");

	// a rejected word reports page zero and a failed integrity flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> (page_index == '0) && !store_ok)
		else $error("rejected word with page index or store_ok set");

	// integrity flag only with a clean violation count
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && store_ok) |-> (violation_count == '0))
		else $error("store_ok with nonzero violation count");

endmodule

// ===== tb/paged_tag_cache_commit_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paged_tag_cache_commit_unit_test: self-checking bench for the commit unit
// Drives tag/entry words through the valid/stall handshake with random
// idling on both sides. Each accepted word is run through a cycle-free
// model of the page table (tags, fill counts, round-robin pointer and the
// saturating violation counter). Every result word is checked field by
// field against the oldest expected one.
// ----------------------------------------------------------------------------
module paged_tag_cache_commit_unit_test;
	import ptcc_pkg::*;

	localparam int PAGES      = 16;
	localparam int SLOTS      = 16;
	localparam int CYCLE_MAX  = 1000000;
	localparam int RAND_WORDS = 1880;
	localparam int TAIL_WORDS = 100;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [ENTRY_W-1:0] entry;
	} commit_word_t;

	typedef struct packed {
		logic              rejected;
		logic [IDX_W-1:0]  page_index;
		logic [VIOL_W-1:0] violation_count;
		logic              store_ok;
	} commit_result_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [TAG_W-1:0]   commit_tag = '0;
	logic [ENTRY_W-1:0] entry_hash = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic               rejected;
	logic [IDX_W-1:0]   page_index;
	logic [VIOL_W-1:0]  violation_count;
	logic               store_ok;

	commit_word_t   commit_words_q[$];
	commit_result_t expected_results_q[$];
	commit_word_t   next_word;
	commit_result_t seen_result;
	commit_result_t want_result;

	// page table as the block should hold it
	logic [TAG_W-1:0]  tag_of_page[PAGES] = '{default: '0};
	int                fill_of_page[PAGES] = '{default: 0};
	int                next_alloc_page = 0;
	logic [VIOL_W-1:0] zero_tag_cnt = '0;

	int          idle_pct = 0;
	int          in_gap_left = 0;
	int          out_stall_left = 0;
	int          mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;

	paged_tag_cache_commit_unit #(
		.PAGES(PAGES),
		.SLOTS(SLOTS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.commit_tag     (commit_tag),
		.entry_hash     (entry_hash),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.rejected       (rejected),
		.page_index     (page_index),
		.violation_count(violation_count),
		.store_ok       (store_ok)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// apply one committed word to the page table, return the result word
	function automatic commit_result_t predict_commit(input logic [TAG_W-1:0] tag);
		commit_result_t r;
		int target;
		int slot;
		int p;
		r = '0;
		if (tag == '0) begin
			if (zero_tag_cnt != VIOL_MAX)
				zero_tag_cnt = zero_tag_cnt + 1'b1;
			r.rejected = 1'b1;
		end else begin
			// highest matching page wins
			target = -1;
			for (p = 0; p < PAGES; p++) begin
				if (tag_of_page[p] == tag)
					target = p;
			end
			// miss: take over the page at the round-robin pointer
			if (target < 0) begin
				target = next_alloc_page;
				tag_of_page[target] = tag;
				fill_of_page[target] = 0;
				next_alloc_page = (target + 1 >= PAGES) ? 0 : target + 1;
			end
			// full page wraps to slot 0
			slot = fill_of_page[target];
			if (slot >= SLOTS)
				slot = 0;
			fill_of_page[target] = slot + 1;
			r.page_index = target[IDX_W-1:0];
		end
		r.violation_count = zero_tag_cnt;
		r.store_ok = (zero_tag_cnt == '0);
		for (p = 0; p < PAGES; p++) begin
			if (fill_of_page[p] > SLOTS)
				r.store_ok = 1'b0;
		end
		return r;
	endfunction

	// input driver: presents queued words, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			commit_tag  <= '0;
			entry_hash  <= '0;
			in_gap_left <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				expected_results_q.push_back(predict_commit(commit_tag));
			if (in_gap_left > 0) begin
				in_valid    <= 1'b0;
				in_gap_left <= in_gap_left - 1;
			end else if (commit_words_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				in_valid    <= 1'b0;
				in_gap_left <= $urandom_range(0, 3);
			end else begin
				next_word  = commit_words_q.pop_front();
				in_valid   <= 1'b1;
				commit_tag <= next_word.tag;
				entry_hash <= next_word.entry;
			end
		end
	end

	// result monitor: checks accepted words, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall      <= 1'b0;
			out_stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_result = '{rejected, page_index, violation_count, store_ok};
				if (expected_results_q.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual %p",
						$time, seen_result);
					mismatch_cnt++;
				end else begin
					want_result = expected_results_q.pop_front();
					if (seen_result.rejected !== want_result.rejected) begin
						$display("%0t: rejected mismatch, expected %0d, actual %0d",
							$time, want_result.rejected, seen_result.rejected);
						mismatch_cnt++;
					end
					if (seen_result.page_index !== want_result.page_index) begin
						$display("%0t: page_index mismatch, expected %0d, actual %0d",
							$time, want_result.page_index, seen_result.page_index);
						mismatch_cnt++;
					end
					if (seen_result.violation_count !== want_result.violation_count) begin
						$display("%0t: violation_count mismatch, expected %0d, actual %0d",
							$time, want_result.violation_count,
							seen_result.violation_count);
						mismatch_cnt++;
					end
					if (seen_result.store_ok !== want_result.store_ok) begin
						$display("%0t: store_ok mismatch, expected %0d, actual %0d",
							$time, want_result.store_ok, seen_result.store_ok);
						mismatch_cnt++;
					end
				end
			end
			if (out_stall_left > 0) begin
				out_stall      <= 1'b1;
				out_stall_left <= out_stall_left - 1;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				out_stall      <= 1'b1;
				out_stall_left <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// run limit
	initial begin
		while (cycle_cnt < CYCLE_MAX) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic push_word(input logic [TAG_W-1:0] tag, input logic [ENTRY_W-1:0] entry);
		commit_word_t w;
		w.tag = tag;
		w.entry = entry;
		commit_words_q.push_back(w);
	endtask

	task automatic wait_drained();
		while (commit_words_q.size() != 0 || expected_results_q.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	function automatic logic [TAG_W-1:0] nonzero_tag();
		logic [TAG_W-1:0] t;
		t = $urandom;
		while (t == '0)
			t = $urandom;
		return t;
	endfunction

	// stimulus
	initial begin
		logic [TAG_W-1:0] tag_pool[32];
		int pool_len;
		int phase;
		int i;
		int pick;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first miss, all-ones tag, hit, full page wrap, zero tags, then a new miss and hit
		idle_pct = 20;
		push_word(32'h0000_0001, '0);
		push_word('1, '1);
		push_word(32'h0000_0001, 64'h8000_0000_0000_0001);
		for (i = 0; i < 15; i++)
			push_word(32'h0000_0001, {$urandom, $urandom});
		push_word('1, 64'h5555_5555_aaaa_aaaa);
		push_word('0, '1);
		push_word('0, '0);
		push_word(32'h8000_0000, 64'haaaa_aaaa_5555_5555);
		push_word(32'h8000_0000, '0);
		wait_drained();

		// random: small pools give hits and page wraps, large ones thrash the pointer
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct = 30;
					pool_len = 6;
				end
				1: begin
					idle_pct = 0;
					pool_len = 20;
				end
				2: begin
					idle_pct = 60;
					pool_len = 12;
				end
				default: begin
					idle_pct = 25;
					pool_len = 32;
				end
			endcase
			for (i = 0; i < pool_len; i++)
				tag_pool[i] = nonzero_tag();
			for (i = 0; i < RAND_WORDS / 4; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					push_word('0, {$urandom, $urandom});
				else if (pick < 15)
					push_word($urandom, {$urandom, $urandom});
				else
					push_word(tag_pool[$urandom_range(0, pool_len - 1)],
						{$urandom, $urandom});
			end
			wait_drained();
		end

		// last part, no idling: zero tags mixed with hits on a few pages
		idle_pct = 0;
		for (i = 0; i < TAIL_WORDS; i++) begin
			if (i % 4 == 0)
				push_word('0, {$urandom, $urandom});
			else
				push_word(tag_pool[$urandom_range(0, 3)], {$urandom, $urandom});
		end
		wait_drained();

		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0 && expected_results_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
